// ----- rtl/teg_pkg.sv -----
// Shared types, codes and helpers of the thermal erosion grid.
package teg_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 128;

   // operation codes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_RUN   = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_STRENGTH    = 2'd2;
   localparam logic [1:0] CSR_PASS_COUNT  = 2'd3;

   localparam int THR_BASE = 655;   // 0.01
   localparam int THR_GAIN = 3277;  // 0.05

   typedef struct packed {
      logic [1:0]         operation;
      logic [7:0]         cell_x;
      logic [6:0]         cell_y;
      logic signed [31:0] height_in;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] height_out;
      logic               out_of_range;
   } rsp_item_type;

   // grid sizes already clamped
   typedef struct packed {
      logic [8:0]  grid_width;
      logic [7:0]  grid_height;
      logic [17:0] strength;
      logic [9:0]  passes;
   } cfg_type;

   typedef struct packed {
      logic               write;
      logic               read;
      logic               run;
      logic signed [31:0] data;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } stat_type;

   // 3x3 window order: centre first, then the 8 neighbours in scan order
   function automatic logic [1:0] win_dy(input logic [3:0] j);
      logic [1:0] r;
      case (j)
         4'd0:                      r = 2'd1;
         4'd1, 4'd2, 4'd3:          r = 2'd0;
         4'd4, 4'd5:                r = 2'd1;
         default:                   r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] win_dx(input logic [3:0] j);
      logic [1:0] r;
      case (j)
         4'd0:                      r = 2'd1;
         4'd1, 4'd4, 4'd6:          r = 2'd0;
         4'd2, 4'd7:                r = 2'd1;
         default:                   r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
      logic signed [31:0] r;
      if (v > 38'sh007FFFFFFF)
         r = 32'sh7FFFFFFF;
      else if (v < -38'sh0080000000)
         r = -32'sh80000000;
      else
         r = v[31:0];
      return r;
   endfunction

endpackage

// ----- rtl/teg_engine.sv -----
// Height memories and the erosion sequencer around one shared multiplier.
module teg_engine #(
   parameter int MAX_WIDTH  = teg_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = teg_pkg::MAX_HEIGHT_DEF,
   localparam int CELLS = MAX_WIDTH * MAX_HEIGHT,
   localparam int AW    = $clog2(CELLS)
) (
   input  logic                clock,
   input  logic                reset,
   input  teg_pkg::cfg_type    cfg,
   input  teg_pkg::cmd_type    cmd,
   input  logic [AW-1:0]       cmd_addr,
   output teg_pkg::stat_type   stat,
   output logic signed [31:0]  rd_data
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);

   typedef enum logic [3:0] {
      ST_IDLE, ST_THR, ST_COPY, ST_COPY_END, ST_WIN, ST_WIN_TAIL, ST_EVAL,
      ST_MUL_LO, ST_MUL_HI, ST_CUR_C, ST_CUR_L, ST_CUR_W, ST_NEXT, ST_FINISH
   } state_type;

   logic signed [31:0] cur_mem  [CELLS];
   logic signed [31:0] snap_mem [CELLS];

   state_type          state_ff, state_in;
   logic [AW-1:0]      cnt_ff, cnt_in;
   logic               copy_wv_ff, copy_wv_in;
   logic [AW-1:0]      copy_wa_ff, copy_wa_in;
   logic [XW-1:0]      x_ff, x_in;
   logic [YW-1:0]      y_ff, y_in;
   logic [3:0]         j_ff, j_in;
   logic               rv_ff, rv_in;
   logic [3:0]         rj_ff, rj_in;
   logic [AW-1:0]      ra_ff, ra_in;
   logic signed [31:0] center_ff, center_in;
   logic signed [31:0] low_ff, low_in;
   logic [AW-1:0]      low_addr_ff, low_addr_in;
   logic               found_ff, found_in;
   logic [9:0]         pass_ff, pass_in;
   logic [14:0]        thr_ff, thr_in;
   logic [32:0]        excess_ff, excess_in;
   logic [34:0]        prod_lo_ff, prod_lo_in;
   logic [34:0]        prod_hi_ff, prod_hi_in;
   logic [35:0]        tr_ff, tr_in;
   logic signed [31:0] cur_rd_ff;
   logic signed [31:0] snap_rd_ff;

   logic [AW-1:0]      cur_ra, cur_wa, cell_addr, win_addr;
   logic               cur_we;
   logic signed [31:0] cur_wd;
   logic [16:0]        mul_a;
   logic [34:0]        mul_p;
   logic [32:0]        drop;

   // the shared multiplier
   assign mul_p = 35'(mul_a) * 35'(cfg.strength);

   assign cell_addr = AW'(AW'(y_ff) * AW'(MAX_WIDTH) + AW'(x_ff));
   assign win_addr  = AW'(cell_addr + AW'(teg_pkg::win_dy(j_ff)) * AW'(MAX_WIDTH)
                          + AW'(teg_pkg::win_dx(j_ff)) - AW'(MAX_WIDTH + 1));
   assign drop      = 33'({center_ff[31], center_ff}) - 33'({low_ff[31], low_ff});

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      copy_wv_in  = 1'b0;
      copy_wa_in  = cnt_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      j_in        = j_ff;
      rv_in       = 1'b0;
      rj_in       = j_ff;
      ra_in       = win_addr;
      center_in   = center_ff;
      low_in      = low_ff;
      low_addr_in = low_addr_ff;
      found_in    = found_ff;
      pass_in     = pass_ff;
      thr_in      = thr_ff;
      excess_in   = excess_ff;
      prod_lo_in  = prod_lo_ff;
      prod_hi_in  = prod_hi_ff;
      tr_in       = tr_ff;
      mul_a       = excess_ff[16:0];
      cur_ra      = cmd_addr;
      cur_we      = 1'b0;
      cur_wa      = cmd_addr;
      cur_wd      = cmd.data;

      // window data arrives in the cycle after its read
      if (rv_ff) begin
         if (rj_ff == 4'd0) begin
            center_in = snap_rd_ff;
            low_in    = snap_rd_ff;
            found_in  = 1'b0;
         end else if (snap_rd_ff < low_ff) begin
            low_in      = snap_rd_ff;
            low_addr_in = ra_ff;
            found_in    = 1'b1;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            cur_we = cmd.write;
            if (cmd.run) begin
               pass_in  = '0;
               state_in = ST_THR;
            end
         end
         ST_THR: begin
            mul_a  = 17'(teg_pkg::THR_GAIN);
            thr_in = 15'(15'(teg_pkg::THR_BASE) + 15'((36'(mul_p) + 36'd32768) >> 16));
            cnt_in = '0;
            state_in = (cfg.passes == 10'd0) ? ST_FINISH : ST_COPY;
         end
         ST_COPY: begin
            cur_ra     = cnt_ff;
            copy_wv_in = 1'b1;
            if (32'(cnt_ff) == CELLS - 1) begin
               state_in = ST_COPY_END;
            end else begin
               cnt_in = AW'(cnt_ff + 1'b1);
            end
         end
         ST_COPY_END: begin
            x_in     = XW'(1);
            y_in     = YW'(1);
            j_in     = '0;
            state_in = ST_WIN;
         end
         ST_WIN: begin
            rv_in = 1'b1;
            if (j_ff == 4'd8) begin
               j_in     = '0;
               state_in = ST_WIN_TAIL;
            end else begin
               j_in = j_ff + 4'd1;
            end
         end
         ST_WIN_TAIL: state_in = ST_EVAL;
         ST_EVAL: begin
            excess_in = drop - 33'(thr_ff);
            if (found_ff && (drop > 33'(thr_ff)))
               state_in = ST_MUL_LO;
            else
               state_in = ST_NEXT;
         end
         ST_MUL_LO: begin
            mul_a      = excess_ff[16:0];
            prod_lo_in = mul_p;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            mul_a      = {1'b0, excess_ff[32:17]};
            prod_hi_in = mul_p;
            state_in   = ST_CUR_C;
         end
         ST_CUR_C: begin
            tr_in    = 36'(prod_hi_ff) + 36'(prod_lo_ff[34:17]);
            cur_ra   = cell_addr;
            state_in = ST_CUR_L;
         end
         ST_CUR_L: begin
            cur_we   = 1'b1;
            cur_wa   = cell_addr;
            cur_wd   = teg_pkg::sat32($signed({{6{cur_rd_ff[31]}}, cur_rd_ff})
                                      - $signed({2'b00, tr_ff}));
            cur_ra   = low_addr_ff;
            state_in = ST_CUR_W;
         end
         ST_CUR_W: begin
            cur_we   = 1'b1;
            cur_wa   = low_addr_ff;
            cur_wd   = teg_pkg::sat32($signed({{6{cur_rd_ff[31]}}, cur_rd_ff})
                                      + $signed({2'b00, tr_ff}));
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            state_in = ST_WIN;
            if (32'(x_ff) == 32'(cfg.grid_width) - 32'd2) begin
               x_in = XW'(1);
               if (32'(y_ff) == 32'(cfg.grid_height) - 32'd2) begin
                  cnt_in = '0;
                  if (pass_ff + 10'd1 == cfg.passes) begin
                     state_in = ST_FINISH;
                  end else begin
                     pass_in  = pass_ff + 10'd1;
                     state_in = ST_COPY;
                  end
               end else begin
                  y_in = y_ff + YW'(1);
               end
            end else begin
               x_in = x_ff + XW'(1);
            end
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         copy_wv_ff <= 1'b0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         copy_wv_ff <= copy_wv_in;
         rv_ff      <= rv_in;
      end
      cnt_ff      <= cnt_in;
      copy_wa_ff  <= copy_wa_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      j_ff        <= j_in;
      rj_ff       <= rj_in;
      ra_ff       <= ra_in;
      center_ff   <= center_in;
      low_ff      <= low_in;
      low_addr_ff <= low_addr_in;
      found_ff    <= found_in;
      pass_ff     <= pass_in;
      thr_ff      <= thr_in;
      excess_ff   <= excess_in;
      prod_lo_ff  <= prod_lo_in;
      prod_hi_ff  <= prod_hi_in;
      tr_ff       <= tr_in;
   end

   // live grid: one write, one registered read
   always_ff @(posedge clock) begin
      if (cur_we)
         cur_mem[cur_wa] <= cur_wd;
      cur_rd_ff <= cur_mem[cur_ra];
   end

   // snapshot: filled by the copy sweep, read by the window scan
   always_ff @(posedge clock) begin
      if (copy_wv_ff)
         snap_mem[copy_wa_ff] <= cur_rd_ff;
      snap_rd_ff <= snap_mem[win_addr];
   end

   assign stat.busy = (state_ff != ST_IDLE);
   assign stat.done = (state_ff == ST_FINISH);
   assign rd_data   = cur_rd_ff;

endmodule

// ----- rtl/thermal_erosion_grid.sv -----
// Top level of the thermal erosion grid: registers, command decode, result word.
//
//  channel  ports                         handshake               word
//  -------  ----------------------------  ----------------------  -------------
//  request  start, busy, req_item         start & !busy           req_item_type
//  result   rsp_valid, rsp_item           one-cycle strobe        rsp_item_type
//  config   csr_valid, csr_ready,         csr_valid & csr_ready   csr_wdata
//           csr_index, csr_wdata
//
// Write, read and unused-code words: result one cycle after accept, busy stays
// low, so one word per cycle. A run word holds busy, on each pass, through the copy sweep
// of the live grid into the snapshot and the window scan, which makes 9 reads per
// cell on the single snapshot read port; a cell that sheds material also takes
// ST_MUL_LO, ST_MUL_HI, ST_CUR_C, ST_CUR_L and ST_CUR_W on the shared multiplier
// and the live grid port. The result strobe comes as busy drops.
// Reset is synchronous; grid memories are not cleared. The receiver cannot stall.
module thermal_erosion_grid #(
   parameter int MAX_WIDTH  = teg_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = teg_pkg::MAX_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  teg_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   output teg_pkg::rsp_item_type rsp_item,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [17:0]           csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

   logic [8:0]  grid_width_ff, grid_width_in;
   logic [7:0]  grid_height_ff, grid_height_in;
   logic [17:0] strength_ff, strength_in;
   logic [9:0]  passes_ff, passes_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_read_ff, rsp_read_in;
   logic        rsp_oor_ff, rsp_oor_in;

   teg_pkg::cfg_type  cfg;
   teg_pkg::cmd_type  cmd;
   teg_pkg::stat_type stat;
   logic [AW-1:0]      cmd_addr;
   logic signed [31:0] rd_data;
   logic               accept, oor, is_rw;

   // grid sizes clamped to [3, MAX]
   always_comb begin
      cfg = '0;
      if (grid_width_ff < 9'd3)
         cfg.grid_width = 9'd3;
      else if (32'(grid_width_ff) > MAX_WIDTH)
         cfg.grid_width = 9'(MAX_WIDTH);
      else
         cfg.grid_width = grid_width_ff;
      if (grid_height_ff < 8'd3)
         cfg.grid_height = 8'd3;
      else if (32'(grid_height_ff) > MAX_HEIGHT)
         cfg.grid_height = 8'(MAX_HEIGHT);
      else
         cfg.grid_height = grid_height_ff;
      cfg.strength = strength_ff;
      cfg.passes   = passes_ff;
   end

   assign accept = start & ~busy;
   assign oor    = (9'(req_item.cell_x) >= cfg.grid_width)
                 || (8'(req_item.cell_y) >= cfg.grid_height);
   assign is_rw  = (req_item.operation == teg_pkg::OP_WRITE)
                 || (req_item.operation == teg_pkg::OP_READ);

   assign cmd_addr  = AW'(AW'(req_item.cell_y) * AW'(MAX_WIDTH) + AW'(req_item.cell_x));
   assign cmd.write = accept && (req_item.operation == teg_pkg::OP_WRITE) && !oor;
   assign cmd.read  = accept && (req_item.operation == teg_pkg::OP_READ) && !oor;
   assign cmd.run   = accept && (req_item.operation == teg_pkg::OP_RUN);
   assign cmd.data  = req_item.height_in;

   teg_engine #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .cmd      (cmd),
      .cmd_addr (cmd_addr),
      .stat     (stat),
      .rd_data  (rd_data)
   );

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      strength_in    = strength_ff;
      passes_in      = passes_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            teg_pkg::CSR_GRID_WIDTH:  grid_width_in  = csr_wdata[8:0];
            teg_pkg::CSR_GRID_HEIGHT: grid_height_in = csr_wdata[7:0];
            teg_pkg::CSR_STRENGTH:    strength_in    = csr_wdata;
            teg_pkg::CSR_PASS_COUNT:  passes_in      = csr_wdata[9:0];
            default:                  passes_in      = passes_ff;
         endcase
      end
      // run result comes from the engine's finish; everything else answers next cycle
      rsp_valid_in = (accept && (req_item.operation != teg_pkg::OP_RUN)) || stat.done;
      rsp_read_in  = cmd.read;
      rsp_oor_in   = accept && is_rw && oor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= 9'd256;
         grid_height_ff <= 8'd128;
         strength_ff    <= 18'd32768;
         passes_ff      <= 10'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         strength_ff    <= strength_in;
         passes_ff      <= passes_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_read_ff <= rsp_read_in;
      rsp_oor_ff  <= rsp_oor_in;
   end

   assign busy                  = stat.busy;
   assign csr_ready             = ~stat.busy;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_item.height_out   = rsp_read_ff ? rd_data : 32'sd0;
   assign rsp_item.out_of_range = rsp_oor_ff;

endmodule

// ----- rtl/teg_checker.sv -----
// Port-level checks of the thermal erosion grid, bound to the top level.
module teg_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input teg_pkg::req_item_type req_item,
   input logic                  rsp_valid,
   input teg_pkg::rsp_item_type rsp_item
);

   // non-run word answers in the next cycle
   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.operation != teg_pkg::OP_RUN) |=> rsp_valid)
      else $error("no result after write/read word");

   // run word makes the block busy
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.operation == teg_pkg::OP_RUN) |=> busy)
      else $error("run word did not raise busy");

   // end of run gives its result
   a_run_done: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("run ended without result");

   // flagged address never carries a height
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.out_of_range) |-> (rsp_item.height_out == 32'sd0))
      else $error("height on out-of-range result");

endmodule

bind thermal_erosion_grid teg_checker u_teg_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
